[sv/fdcr_pkg.sv]
package fdcr_pkg;

	localparam int MAX_DELAY    = 4096;
	localparam int SAMPLE_WIDTH = 16;
	localparam int NCH          = 2;

	// ring address and ring length widths
	localparam int AW = $clog2(MAX_DELAY);
	localparam int LW = AW + 1;

	// unsigned Q0.16 gains, one extra bit to hold 1.0
	localparam int QB = 16;
	localparam int GW = QB + 1;

	// products: interpolation, feedback term, direct term
	localparam int PW = SAMPLE_WIDTH + GW;
	localparam int FW = PW + GW + 1;
	localparam int XW = SAMPLE_WIDTH + GW + 1;

	localparam logic [GW-1:0] ONE_Q = GW'(1) << QB;

	// configuration register indexes
	localparam int IDX_W = 2;
	localparam int CFG_W = GW;
	localparam logic [IDX_W-1:0] REG_DELAY_LENGTH = IDX_W'(0);
	localparam logic [IDX_W-1:0] REG_INTERP_FRAC  = IDX_W'(1);
	localparam logic [IDX_W-1:0] REG_GAIN_ALPHA   = IDX_W'(2);

	typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;

	typedef struct packed {
		logic capture;
		logic rd_next;
		logic mul_old;
		logic mul_new;
		logic mul_alpha;
		logic commit;
	} cmd_t;

	typedef struct packed {
		logic out_free;
	} sts_t;

endpackage

[sv/fdcr_in_if.sv]
interface fdcr_in_if;
	logic valid;
	logic ready;
	logic signed [fdcr_pkg::SAMPLE_WIDTH-1:0] left_in;
	logic signed [fdcr_pkg::SAMPLE_WIDTH-1:0] right_in;

	modport source(output valid, output left_in, output right_in, input ready);
	modport sink(input valid, input left_in, input right_in, output ready);
endinterface

[sv/fdcr_out_if.sv]
interface fdcr_out_if;
	logic valid;
	logic ready;
	logic signed [fdcr_pkg::SAMPLE_WIDTH-1:0] left_out;
	logic signed [fdcr_pkg::SAMPLE_WIDTH-1:0] right_out;

	modport source(output valid, output left_out, output right_out, input ready);
	modport sink(input valid, input left_out, input right_out, output ready);
endinterface

[sv/fdcr_cfg_if.sv]
interface fdcr_cfg_if;
	logic valid;
	logic ready;
	logic [fdcr_pkg::IDX_W-1:0] index;
	logic [fdcr_pkg::CFG_W-1:0] data;

	modport source(output valid, output index, output data, input ready);
	modport sink(input valid, input index, input data, output ready);
endinterface

[sv/fractional_delay_comb_resonator_unit.sv]
// an accepted sample transaction ends with its result on the output register
// a new stereo sample is taken only after the accept cycle, two ring reads on the single
// read port of each channel memory, two more multiply steps and the commit
// a result that is not taken holds the commit and stalls the next sample transaction
// reset: ring position, fill count, frac, alpha and output valid clear asynchronously, length to 2;
// ring contents are not cleared, the fill count keeps unwritten slots from being used
module fractional_delay_comb_resonator_unit (
	input logic        clk,
	input logic        arst_n,
	fdcr_in_if.sink    sample,
	fdcr_out_if.source result,
	fdcr_cfg_if.sink   cfg
);

	fdcr_pkg::cmd_t cmd;
	fdcr_pkg::sts_t sts;
	logic           in_ready;

	fdcr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (sample.valid),
		.sts      (sts),
		.in_ready (in_ready),
		.cmd      (cmd)
	);

	fdcr_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.left_in   (sample.left_in),
		.right_in  (sample.right_in),
		.left_out  (result.left_out),
		.right_out (result.right_out),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.cfg_valid (cfg.valid),
		.cfg_index (cfg.index),
		.cfg_data  (cfg.data)
	);

	assign sample.ready = in_ready;
	assign cfg.ready    = 1'b1;

	// one transaction at a time: no new sample right after one is taken
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) |=> !sample.ready)
		else $error("sample accepted while previous one in flight");

	// a result only appears after a commit
	a_valid_from_commit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(cmd.commit))
		else $error("result valid without commit");

	// a commit never overwrites a result that is still waiting
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!result.valid || result.ready))
		else $error("commit over a pending result");

endmodule

[sv/fdcr_ctrl.sv]
module fdcr_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  fdcr_pkg::sts_t sts,
	output logic           in_ready,
	output fdcr_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD_OLD,
		ST_RD_NEW,
		ST_MUL_NEW,
		ST_MUL_ALPHA,
		ST_COMMIT
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:      if (in_valid) state_q <= ST_RD_OLD;
				ST_RD_OLD:    state_q <= ST_RD_NEW;
				ST_RD_NEW:    state_q <= ST_MUL_NEW;
				ST_MUL_NEW:   state_q <= ST_MUL_ALPHA;
				ST_MUL_ALPHA: state_q <= ST_COMMIT;
				// hold the result until the output register can take it
				ST_COMMIT:    if (sts.out_free) state_q <= ST_IDLE;
				default:      state_q <= ST_IDLE;
			endcase
		end
	end

	assign in_ready      = (state_q == ST_IDLE);
	assign cmd.capture   = (state_q == ST_IDLE) && in_valid;
	assign cmd.rd_next   = (state_q == ST_RD_NEW);
	assign cmd.mul_old   = (state_q == ST_RD_NEW);
	assign cmd.mul_new   = (state_q == ST_MUL_NEW);
	assign cmd.mul_alpha = (state_q == ST_MUL_ALPHA);
	assign cmd.commit    = (state_q == ST_COMMIT) && sts.out_free;

endmodule

[sv/fdcr_dp.sv]
module fdcr_dp (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  fdcr_pkg::cmd_t                        cmd,
	output fdcr_pkg::sts_t                        sts,
	input  fdcr_pkg::sample_t                     left_in,
	input  fdcr_pkg::sample_t                     right_in,
	output fdcr_pkg::sample_t                     left_out,
	output fdcr_pkg::sample_t                     right_out,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	input  logic                                  cfg_valid,
	input  logic [fdcr_pkg::IDX_W-1:0]            cfg_index,
	input  logic [fdcr_pkg::CFG_W-1:0]            cfg_data
);

	localparam int SW = fdcr_pkg::SAMPLE_WIDTH;
	localparam int AW = fdcr_pkg::AW;
	localparam int LW = fdcr_pkg::LW;
	localparam int QB = fdcr_pkg::QB;
	localparam int GW = fdcr_pkg::GW;
	localparam int PW = fdcr_pkg::PW;
	localparam int FW = fdcr_pkg::FW;
	localparam int XW = fdcr_pkg::XW;
	localparam int NCH = fdcr_pkg::NCH;
	localparam int QW = FW - 2 * QB;

	localparam logic signed [FW-1:0] RND  = FW'(1) << (2 * QB - 1);
	localparam logic signed [QW-1:0] SMAX = QW'((1 << (SW - 1)) - 1);
	localparam logic signed [QW-1:0] SMIN = -SMAX - QW'(1);
	localparam logic [LW-1:0] LEN_MAX = LW'(fdcr_pkg::MAX_DELAY);

	// configuration and ring control
	logic [LW-1:0] len_q;
	logic [QB-1:0] frac_q;
	logic [GW-1:0] alpha_q;
	logic [AW-1:0] pos_q;
	logic [LW-1:0] fill_q;
	logic          out_valid_q;

	logic [LW-1:0] pos_inc;
	logic [AW-1:0] nxt_pos;
	logic [AW-1:0] rd_addr;
	logic [GW-1:0] onem_frac;
	logic [GW-1:0] onem_alpha;
	logic          feed;
	logic [LW-1:0] dl_w;
	logic [GW-1:0] ga_w;

	// per channel payload
	logic [SW-1:0]        ring_q   [NCH][fdcr_pkg::MAX_DELAY];
	logic signed [SW-1:0] x_q      [NCH];
	logic signed [SW-1:0] rd_data_q[NCH];
	logic signed [PW-1:0] p_old_q  [NCH];
	logic signed [PW-1:0] interp_q [NCH];
	logic signed [FW-1:0] fb_q     [NCH];
	logic signed [XW-1:0] xp_q     [NCH];
	logic signed [SW-1:0] y        [NCH];
	logic signed [SW-1:0] y_q      [NCH];
	logic signed [FW-1:0] acc      [NCH];
	logic signed [QW-1:0] q        [NCH];

	assign pos_inc    = {1'b0, pos_q} + LW'(1);
	assign nxt_pos    = (pos_inc >= len_q) ? '0 : pos_inc[AW-1:0];
	assign rd_addr    = cmd.rd_next ? nxt_pos : pos_q;
	assign onem_frac  = fdcr_pkg::ONE_Q - {1'b0, frac_q};
	assign onem_alpha = fdcr_pkg::ONE_Q - alpha_q;
	assign feed       = (fill_q >= len_q);
	assign dl_w       = cfg_data[LW-1:0];
	assign ga_w       = cfg_data[GW-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q       <= LW'(2);
			frac_q      <= '0;
			alpha_q     <= '0;
			pos_q       <= '0;
			fill_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					fdcr_pkg::REG_DELAY_LENGTH: begin
						if (dl_w == '0) len_q <= LW'(1);
						else if (dl_w > LEN_MAX) len_q <= LEN_MAX;
						else len_q <= dl_w;
						pos_q  <= '0;
						fill_q <= '0;
					end
					fdcr_pkg::REG_INTERP_FRAC: frac_q <= cfg_data[QB-1:0];
					fdcr_pkg::REG_GAIN_ALPHA: begin
						alpha_q <= (ga_w > fdcr_pkg::ONE_Q) ? fdcr_pkg::ONE_Q : ga_w;
					end
					default: ;
				endcase
			end
			if (cmd.commit) begin
				pos_q <= nxt_pos;
				if (fill_q < len_q) fill_q <= fill_q + LW'(1);
			end
			if (cmd.commit) out_valid_q <= 1'b1;
			else if (out_ready) out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		for (int c = 0; c < NCH; c++) begin
			// round to nearest with ties up, then saturate; until the ring is filled the input passes through
			acc[c] = fb_q[c] + (FW'(xp_q[c]) <<< QB) + RND;
			q[c]   = acc[c][FW-1:2*QB];
			if (!feed) y[c] = x_q[c];
			else if (q[c] > SMAX) y[c] = SMAX[SW-1:0];
			else if (q[c] < SMIN) y[c] = SMIN[SW-1:0];
			else y[c] = q[c][SW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NCH; c++) begin
			rd_data_q[c] <= ring_q[c][rd_addr];
			if (cmd.commit) ring_q[c][pos_q] <= y[c];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			x_q[0] <= left_in;
			x_q[1] <= right_in;
		end
		for (int c = 0; c < NCH; c++) begin
			if (cmd.mul_old) p_old_q[c] <= rd_data_q[c] * $signed({1'b0, frac_q});
			if (cmd.mul_new) begin
				interp_q[c] <= p_old_q[c] + rd_data_q[c] * $signed({1'b0, onem_frac});
			end
			if (cmd.mul_alpha) begin
				fb_q[c] <= interp_q[c] * $signed({1'b0, alpha_q});
				xp_q[c] <= x_q[c] * $signed({1'b0, onem_alpha});
			end
			if (cmd.commit) y_q[c] <= y[c];
		end
	end

	assign sts.out_free = !out_valid_q || out_ready;
	assign out_valid    = out_valid_q;
	assign left_out     = y_q[0];
	assign right_out    = y_q[1];

endmodule
